### rtl/monomial_term_parser_core_macros.svh
// assertion helpers shared by the parser modules
`ifndef MONOMIAL_TERM_PARSER_CORE_MACROS_SVH
`define MONOMIAL_TERM_PARSER_CORE_MACROS_SVH

// same-cycle implication, checked on every rising edge outside reset
`define MTP_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MTP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/mtp_pkg.sv
package mtp_pkg;

	localparam int CH_W      = 8;
	localparam int COEF_W    = 31;
	localparam int MOD_W     = COEF_W + 1;
	localparam int RED_W     = COEF_W + 4;
	localparam int RED_CNT_W = 6;
	localparam int NAMES     = 8;
	localparam int IDX_W     = 3;
	localparam int NUMV_W    = 4;
	localparam int CFG_W     = 64;
	localparam int CFG_IDX_W = 2;
	localparam int STATUS_W  = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_MODULUS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_VAR_NAMES = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_VARS  = 2'd2;

	localparam logic [COEF_W-1:0] MODULUS_RST  = 31'h7FFF_FFFF;
	localparam logic [MOD_W-1:0]  MODULUS_ZERO = 32'h8000_0000;
	localparam logic [NUMV_W-1:0] NUM_VARS_RST = 4'd1;

	localparam logic [CH_W-1:0] CH_CARET = 8'h5E;
	localparam logic [CH_W-1:0] CH_STAR  = 8'h2A;
	localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
	localparam logic [CH_W-1:0] CH_UP_A  = 8'h41;
	localparam logic [CH_W-1:0] CH_UP_Z  = 8'h5A;
	localparam logic [CH_W-1:0] CH_LO_A  = 8'h61;
	localparam logic [CH_W-1:0] CH_LO_Z  = 8'h7A;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK,
		ST_BAD_FIRST,
		ST_UNKNOWN_VAR,
		ST_CARET,
		ST_UNEXPECTED
	} status_t;

	typedef enum logic [3:0] {
		S_START,
		S_COEF,
		S_ITEM,
		S_AFTER_VAR,
		S_CARET,
		S_EXP,
		S_ERROR,
		S_REDUCE,
		S_CHECK,
		S_FINAL,
		S_EMIT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic              coef_one;
		logic              coef_digit;
		logic              red_step;
		logic              final_start;
		logic              exp_first;
		logic              exp_next;
		logic              exp_commit;
		logic              var_hit;
		logic              cur_clear;
		logic              clear_term;
		logic              out_load;
		logic [IDX_W-1:0]  out_idx;
		status_t           out_status;
		logic              out_last;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic              acc_lt_m;
		logic              red_last;
		logic              hit;
		logic [NUMV_W-1:0] n_vars;
	} sts_t;

	function automatic logic is_digit(input logic [CH_W-1:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic is_letter(input logic [CH_W-1:0] c);
		return ((c >= CH_UP_A) && (c <= CH_UP_Z)) || ((c >= CH_LO_A) && (c <= CH_LO_Z));
	endfunction

	function automatic logic is_sep(input logic [CH_W-1:0] c);
		return (c == CH_STAR) || (c == CH_SPACE);
	endfunction

endpackage

### rtl/monomial_term_parser_core.sv
// Monomial term parser. Characters of one monomial arrive one per input transfer, the last one
// flagged by end_of_term; after it the block sends one result per variable in use (index,
// degree, coefficient mod modulus, last on the final one), a single result when none is in use,
// or a single status result when the text is malformed. Separators, letters, carets and exponent
// digits are taken one per cycle. A coefficient digit is accepted, then takes 4 steps of the
// shared bit-serial remainder unit, or a full-width run of steps when the running coefficient is
// not below the modulus, which only happens if the modulus was rewritten in the middle of a term.
// After the final character of a well formed term there is a check state, 31 more remainder steps
// if the coefficient is still not below the modulus, then one result per cycle while out_stall is
// low; a status result follows the final character with no check state. Input is stalled from
// the final character until the last result is in the output register; that register lets a new
// term start while the last result still waits to be taken. Configuration registers: 0 modulus,
// 1 packed variable names (entry zero in the low byte), 2 number of variables in use.
`include "monomial_term_parser_core_macros.svh"

module monomial_term_parser_core #(
	parameter int MAX_VARS    = 8,
	parameter int DEGREE_BITS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration writes
	input  logic                          cfg_we,
	input  logic [mtp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mtp_pkg::CFG_W-1:0]     cfg_data,
	// character stream
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [mtp_pkg::CH_W-1:0]      ch,
	input  logic                          end_of_term,
	// results
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [mtp_pkg::IDX_W-1:0]     var_index,
	output logic [DEGREE_BITS-1:0]        degree,
	output logic [mtp_pkg::COEF_W-1:0]    coefficient,
	output logic [mtp_pkg::STATUS_W-1:0]  status,
	output logic                          last
);
	import mtp_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// parse state machine, emit sequencing and output handshake
	mtp_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.ch          (ch),
		.end_of_term (end_of_term),
		.in_stall    (in_stall),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.sts         (sts),
		.cmd         (cmd)
	);

	// config registers, coefficient remainder unit, name lookup, degree table, result register
	mtp_datapath #(
		.MAX_VARS    (MAX_VARS),
		.DEGREE_BITS (DEGREE_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.ch          (ch),
		.cmd         (cmd),
		.sts         (sts),
		.var_index   (var_index),
		.degree      (degree),
		.coefficient (coefficient),
		.status      (status),
		.last        (last)
	);

	// a status result always stands alone and carries no coefficient
	`MTP_ASSERT_IMPL(a_error_result_alone, out_valid && status != ST_OK, last && coefficient == '0, "status result not final or nonzero")

endmodule

### rtl/mtp_datapath.sv
module mtp_datapath #(
	parameter int MAX_VARS    = 8,
	parameter int DEGREE_BITS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [mtp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mtp_pkg::CFG_W-1:0]     cfg_data,
	input  logic [mtp_pkg::CH_W-1:0]      ch,
	input  mtp_pkg::cmd_t                 cmd,
	output mtp_pkg::sts_t                 sts,
	output logic [mtp_pkg::IDX_W-1:0]     var_index,
	output logic [DEGREE_BITS-1:0]        degree,
	output logic [mtp_pkg::COEF_W-1:0]    coefficient,
	output logic [mtp_pkg::STATUS_W-1:0]  status,
	output logic                          last
);
	import mtp_pkg::*;

	// only eight names exist, so at most eight degrees are ever kept
	localparam int NV  = (MAX_VARS < NAMES) ? MAX_VARS : NAMES;
	localparam int TIW = (NV > 1) ? $clog2(NV) : 1;
	localparam logic [DEGREE_BITS-1:0] DEG_MAX = {DEGREE_BITS{1'b1}};

	logic [COEF_W-1:0]        modulus_q;
	logic [CFG_W-1:0]         names_q;
	logic [NUMV_W-1:0]        numv_q;

	logic [COEF_W-1:0]        acc_q;
	logic [RED_W-1:0]         sh_q;
	logic [RED_CNT_W-1:0]     cnt_q;
	logic [DEGREE_BITS-1:0]   exp_q;
	logic [TIW-1:0]           cur_q;
	logic                     cur_valid_q;
	logic [DEGREE_BITS-1:0]   deg_q [NV];

	logic [MOD_W-1:0]         m_eff;
	logic [NUMV_W-1:0]        n_vars;
	logic [3:0]               dgt;
	logic [RED_W-1:0]         v;
	logic [MOD_W-1:0]         t;
	logic [MOD_W-1:0]         diff;
	logic                     ge;
	logic [NAMES-1:0]         match;
	logic [IDX_W-1:0]         hit_idx;
	logic [DEGREE_BITS+3:0]   exp_wide;
	logic [DEGREE_BITS-1:0]   exp_nxt;

	assign m_eff  = (modulus_q == '0) ? MODULUS_ZERO : {1'b0, modulus_q};
	assign n_vars = (numv_q > NUMV_W'(NV)) ? NUMV_W'(NV) : numv_q;
	assign dgt    = 4'(ch - CH_ZERO);

	// 10*acc + digit
	assign v = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) + RED_W'(dgt);

	// one restoring step of the remainder
	assign t    = {acc_q, sh_q[RED_W-1]};
	assign ge   = (t >= m_eff);
	assign diff = t - m_eff;

	// name lookup, lowest matching entry wins
	always_comb begin
		match   = '0;
		hit_idx = '0;
		for (int i = 0; i < NAMES; i++) begin
			match[i] = (NUMV_W'(i) < n_vars) && (names_q[i*CH_W +: CH_W] == ch);
		end
		for (int i = NAMES - 1; i >= 0; i--) begin
			if (match[i]) begin
				hit_idx = IDX_W'(i);
			end
		end
	end

	assign exp_wide = ({4'b0, exp_q} << 3) + ({4'b0, exp_q} << 1) + (DEGREE_BITS+4)'(dgt);

	always_comb begin
		exp_nxt = exp_q;
		if (cmd.exp_first) begin
			exp_nxt = DEGREE_BITS'(dgt);
		end else if (cmd.exp_next) begin
			exp_nxt = (exp_wide > (DEGREE_BITS+4)'(DEG_MAX)) ? DEG_MAX : exp_wide[DEGREE_BITS-1:0];
		end
	end

	assign sts.acc_lt_m = ({1'b0, acc_q} < m_eff);
	assign sts.red_last = (cnt_q == RED_CNT_W'(1));
	assign sts.hit      = |match;
	assign sts.n_vars   = n_vars;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= MODULUS_RST;
			names_q   <= '0;
			numv_q    <= NUM_VARS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MODULUS:   modulus_q <= cfg_data[COEF_W-1:0];
				CFG_VAR_NAMES: names_q   <= cfg_data;
				CFG_NUM_VARS:  numv_q    <= cfg_data[NUMV_W-1:0];
				default: ;
			endcase
		end
	end

	// coefficient accumulator doubles as the remainder of the reduction unit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			sh_q  <= '0;
			cnt_q <= '0;
		end else if (cmd.clear_term) begin
			acc_q <= '0;
			cnt_q <= '0;
		end else if (cmd.coef_one) begin
			acc_q <= COEF_W'(1);
		end else if (cmd.coef_digit) begin
			if (sts.acc_lt_m) begin
				// v < 16*m, so the upper bits are already reduced
				acc_q <= v[RED_W-1:4];
				sh_q  <= {v[3:0], {COEF_W{1'b0}}};
				cnt_q <= RED_CNT_W'(4);
			end else begin
				acc_q <= '0;
				sh_q  <= v;
				cnt_q <= RED_CNT_W'(RED_W);
			end
		end else if (cmd.final_start) begin
			acc_q <= '0;
			sh_q  <= {acc_q, 4'b0};
			cnt_q <= RED_CNT_W'(COEF_W);
		end else if (cmd.red_step) begin
			acc_q <= ge ? diff[COEF_W-1:0] : t[COEF_W-1:0];
			sh_q  <= sh_q << 1;
			cnt_q <= cnt_q - RED_CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_q       <= '0;
			cur_q       <= '0;
			cur_valid_q <= 1'b0;
			for (int i = 0; i < NV; i++) begin
				deg_q[i] <= '0;
			end
		end else if (cmd.clear_term) begin
			exp_q       <= '0;
			cur_valid_q <= 1'b0;
			for (int i = 0; i < NV; i++) begin
				deg_q[i] <= '0;
			end
		end else begin
			exp_q <= exp_nxt;
			// a new variable overrides a commit to the same entry
			for (int i = 0; i < NV; i++) begin
				if (cmd.var_hit && hit_idx == IDX_W'(i)) begin
					deg_q[i] <= DEGREE_BITS'(1);
				end else if (cmd.exp_commit && cur_valid_q && cur_q == TIW'(i)) begin
					deg_q[i] <= exp_nxt;
				end
			end
			if (cmd.var_hit) begin
				cur_q       <= hit_idx[TIW-1:0];
				cur_valid_q <= 1'b1;
			end else if (cmd.exp_commit || cmd.cur_clear) begin
				cur_valid_q <= 1'b0;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (cmd.out_status != ST_OK) begin
				var_index   <= '0;
				degree      <= '0;
				coefficient <= '0;
			end else begin
				var_index   <= cmd.out_idx;
				degree      <= deg_q[cmd.out_idx[TIW-1:0]];
				coefficient <= acc_q;
			end
			status <= cmd.out_status;
			last   <= cmd.out_last;
		end
	end

endmodule

### rtl/mtp_ctrl.sv
`include "monomial_term_parser_core_macros.svh"

module mtp_ctrl (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic [mtp_pkg::CH_W-1:0] ch,
	input  logic                     end_of_term,
	output logic                     in_stall,
	output logic                     out_valid,
	input  logic                     out_stall,
	input  mtp_pkg::sts_t            sts,
	output mtp_pkg::cmd_t            cmd
);
	import mtp_pkg::*;

	state_t           state_q, state_d;
	status_t          err_q;
	logic             pend_q;
	logic [IDX_W-1:0] k_q;
	logic             out_valid_q;

	logic    parse;
	logic    acc;
	logic    slot_free;
	logic    out_last;

	// char decode
	state_t  si_ph, ph_c;
	status_t si_fail, fail_c, fail_tot;
	logic    si_hit, si_clr;
	logic    f_one, f_digit, f_exp_first, f_exp_next, f_commit, f_hit, f_clr;

	always_comb begin
		unique case (state_q) inside
			S_START, S_COEF, S_ITEM, S_AFTER_VAR, S_CARET, S_EXP, S_ERROR: parse = 1'b1;
			default: parse = 1'b0;
		endcase
	end

	assign in_stall  = !parse;
	assign acc       = in_valid && parse;
	assign out_valid = out_valid_q;
	assign slot_free = !out_valid_q || !out_stall;
	assign out_last  = (err_q != ST_OK) || (sts.n_vars == '0) ||
		(({1'b0, k_q} + NUMV_W'(1)) == sts.n_vars);

	// character where a new item may begin
	always_comb begin
		si_ph   = S_ERROR;
		si_fail = ST_UNEXPECTED;
		si_hit  = 1'b0;
		si_clr  = 1'b0;
		if (is_sep(ch)) begin
			si_ph   = S_ITEM;
			si_fail = ST_OK;
		end else if (is_letter(ch)) begin
			if (sts.hit) begin
				si_ph   = S_AFTER_VAR;
				si_fail = ST_OK;
				si_hit  = 1'b1;
			end else begin
				si_fail = ST_UNKNOWN_VAR;
			end
		end else if (ch == CH_CARET) begin
			si_ph   = S_CARET;
			si_fail = ST_OK;
			si_clr  = 1'b1;
		end
	end

	always_comb begin
		ph_c        = state_q;
		fail_c      = ST_OK;
		f_one       = 1'b0;
		f_digit     = 1'b0;
		f_exp_first = 1'b0;
		f_exp_next  = 1'b0;
		f_commit    = 1'b0;
		f_hit       = 1'b0;
		f_clr       = 1'b0;
		case (state_q)
			S_START: begin
				if (is_letter(ch)) begin
					f_one  = 1'b1;
					ph_c   = si_ph;
					fail_c = si_fail;
					f_hit  = si_hit;
				end else if (is_digit(ch)) begin
					f_digit = 1'b1;
					ph_c    = S_REDUCE;
				end else begin
					ph_c   = S_ERROR;
					fail_c = ST_BAD_FIRST;
				end
			end
			S_COEF: begin
				if (is_digit(ch)) begin
					f_digit = 1'b1;
					ph_c    = S_REDUCE;
				end else begin
					ph_c   = si_ph;
					fail_c = si_fail;
					f_hit  = si_hit;
					f_clr  = si_clr;
				end
			end
			S_ITEM: begin
				ph_c   = si_ph;
				fail_c = si_fail;
				f_hit  = si_hit;
				f_clr  = si_clr;
			end
			S_AFTER_VAR: begin
				if (ch == CH_CARET) begin
					ph_c = S_CARET;
				end else begin
					ph_c   = si_ph;
					fail_c = si_fail;
					f_hit  = si_hit;
					f_clr  = si_clr;
				end
			end
			S_CARET: begin
				if (is_digit(ch)) begin
					f_exp_first = 1'b1;
					ph_c        = S_EXP;
				end else begin
					ph_c   = S_ERROR;
					fail_c = ST_CARET;
				end
			end
			S_EXP: begin
				if (is_digit(ch)) begin
					f_exp_next = 1'b1;
				end else begin
					f_commit = 1'b1;
					ph_c     = si_ph;
					fail_c   = si_fail;
					f_hit    = si_hit;
					f_clr    = si_clr;
				end
			end
			default: ;
		endcase
		// a caret as the final character
		fail_tot = fail_c;
		if (fail_c == ST_OK && end_of_term && ph_c == S_CARET) begin
			fail_tot = ST_CARET;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_START, S_COEF, S_ITEM, S_AFTER_VAR, S_CARET, S_EXP, S_ERROR: begin
				if (acc) begin
					if (fail_tot != ST_OK || ph_c == S_ERROR) begin
						state_d = end_of_term ? S_EMIT : S_ERROR;
					end else if (end_of_term && ph_c != S_REDUCE) begin
						state_d = S_CHECK;
					end else begin
						state_d = ph_c;
					end
				end
			end
			S_REDUCE: begin
				if (sts.red_last) begin
					state_d = pend_q ? S_CHECK : S_COEF;
				end
			end
			S_CHECK: state_d = sts.acc_lt_m ? S_EMIT : S_FINAL;
			S_FINAL: begin
				if (sts.red_last) begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (slot_free && out_last) begin
					state_d = S_START;
				end
			end
			default: state_d = S_START;
		endcase
	end

	// datapath commands
	always_comb begin
		cmd             = '0;
		cmd.coef_one    = acc && f_one;
		cmd.coef_digit  = acc && f_digit;
		cmd.exp_first   = acc && f_exp_first;
		cmd.exp_next    = acc && f_exp_next;
		cmd.exp_commit  = acc && (f_commit || (end_of_term && ph_c == S_EXP));
		cmd.var_hit     = acc && f_hit;
		cmd.cur_clear   = acc && f_clr;
		cmd.red_step    = (state_q == S_REDUCE) || (state_q == S_FINAL);
		cmd.final_start = (state_q == S_CHECK) && !sts.acc_lt_m;
		cmd.out_load    = (state_q == S_EMIT) && slot_free;
		cmd.clear_term  = cmd.out_load && out_last;
		cmd.out_idx     = k_q;
		cmd.out_status  = err_q;
		cmd.out_last    = out_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_START;
			err_q       <= ST_OK;
			pend_q      <= 1'b0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.clear_term) begin
				err_q <= ST_OK;
			end else if (acc && state_q != S_ERROR && fail_tot != ST_OK) begin
				err_q <= fail_tot;
			end
			if (cmd.coef_digit) begin
				pend_q <= end_of_term;
			end
			if (cmd.clear_term) begin
				k_q <= '0;
			end else if (cmd.out_load) begin
				k_q <= k_q + IDX_W'(1);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`MTP_ASSERT_NEXT(a_eot_blocks_input, in_valid && !in_stall && end_of_term, in_stall, "input taken right after final character")
	`MTP_ASSERT_IMPL(a_error_has_code, state_q == S_ERROR, err_q != ST_OK, "error phase without status code")
	`MTP_ASSERT_IMPL(a_load_into_free_slot, cmd.out_load, !out_valid || !out_stall, "result overwrites a stalled transfer")

endmodule

### dv/tb.sv
module tb;
	import mtp_pkg::*;

	localparam int DEG_W         = 8;
	localparam int TABLE_SLOTS   = 8;
	localparam int RANDOM_CHARS  = 500;
	localparam int SETTLE_CYCLES = 40;
	localparam int DRAIN_CYCLES  = 50;
	localparam int QUIET_LIMIT   = 3000;
	localparam int SHOWN_ERRORS  = 10;

	localparam logic [COEF_W-1:0] MOD_MAX   = 31'h7FFF_FFFF;
	// entry zero is 'x', then 'y', 'z', 'd', ...
	localparam logic [CFG_W-1:0]  NAMES_XYZ = "hgfedzyx";

	// one expected result transfer
	typedef struct {
		logic [IDX_W-1:0]  var_index;
		logic [DEG_W-1:0]  degree;
		logic [COEF_W-1:0] coefficient;
		status_t           status;
		logic              last;
	} term_result_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 in_valid;
	logic                 in_stall;
	logic [CH_W-1:0]      ch;
	logic                 end_of_term;
	logic                 out_valid;
	logic                 out_stall;
	logic [IDX_W-1:0]     var_index;
	logic [DEG_W-1:0]     degree;
	logic [COEF_W-1:0]    coefficient;
	logic [STATUS_W-1:0]  status;
	logic                 last;

	monomial_term_parser_core #(
		.MAX_VARS   (TABLE_SLOTS),
		.DEGREE_BITS(DEG_W)
	) i_dut (.*);

	// mirror of the register file
	logic [COEF_W-1:0] modulus_q;
	logic [CFG_W-1:0]  names_q;
	logic [NUMV_W-1:0] nvars_q;

	// mirror of the parser state for the term in flight
	state_t            term_phase;
	logic [COEF_W-1:0] coef_run;
	logic [DEG_W-1:0]  exp_run;
	logic [IDX_W-1:0]  cur_var;
	logic              cur_live;
	logic [DEG_W-1:0]  deg_tab [TABLE_SLOTS];
	status_t           term_err;

	// results still owed by the block, oldest first
	term_result_t pending_results [$];

	int unsigned mismatches   = 0;
	int unsigned quiet_cycles = 0;
	bit          idle_in      = 1'b1;
	bit          idle_out     = 1'b1;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// term parser mirror
	// ---------------------------------------------------------------

	function automatic bit letter_char(input logic [CH_W-1:0] c);
		return (c >= CH_UP_A && c <= CH_UP_Z) || (c >= CH_LO_A && c <= CH_LO_Z);
	endfunction

	function automatic bit digit_char(input logic [CH_W-1:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	// a modulus of zero stands for 2^31
	function automatic longint unsigned field_size();
		return (modulus_q == '0) ? (64'd1 << COEF_W) : 64'(modulus_q);
	endfunction

	// count register clamped to the table size
	function automatic int unsigned names_in_use();
		return (nvars_q > TABLE_SLOTS) ? TABLE_SLOTS : int'(nvars_q);
	endfunction

	function automatic void clear_term();
		term_phase = S_START;
		coef_run   = '0;
		exp_run    = '0;
		cur_var    = '0;
		cur_live   = 1'b0;
		foreach (deg_tab[i]) deg_tab[i] = '0;
		term_err   = ST_OK;
	endfunction

	// only the first error of a term is kept
	function automatic void raise_error(input status_t code);
		if (term_phase != S_ERROR) begin
			term_err   = code;
			term_phase = S_ERROR;
		end
	endfunction

	// exponent binds only to a variable right before the caret
	function automatic void store_exponent();
		if (cur_live) deg_tab[cur_var] = exp_run;
		cur_live = 1'b0;
	endfunction

	// character where a new item (separator, variable or caret) may begin
	function automatic void begin_item(input logic [CH_W-1:0] c);
		int unsigned n;
		n = names_in_use();
		if (c == CH_STAR || c == CH_SPACE) begin
			term_phase = S_ITEM;
		end else if (letter_char(c)) begin
			// first matching table entry wins
			for (int unsigned i = 0; i < n; i++) begin
				if (names_q[8*i +: 8] == c) begin
					deg_tab[i] = DEG_W'(1);
					cur_var    = IDX_W'(i);
					cur_live   = 1'b1;
					term_phase = S_AFTER_VAR;
					return;
				end
			end
			raise_error(ST_UNKNOWN_VAR);
		end else if (c == CH_CARET) begin
			// stray caret: exponent is parsed and dropped
			cur_live   = 1'b0;
			term_phase = S_CARET;
		end else begin
			raise_error(ST_UNEXPECTED);
		end
	endfunction

	// advance the mirror by one accepted character, queue what it causes
	function automatic void parse_char(input logic [CH_W-1:0] c, input logic eot);
		longint unsigned m, d, coef, tmp;
		int unsigned n;
		m = field_size();
		d = 64'(CH_W'(c - CH_ZERO));
		case (term_phase)
			S_START: begin
				if (letter_char(c)) begin
					coef_run = COEF_W'(1);
					begin_item(c);
				end else if (digit_char(c)) begin
					coef_run   = COEF_W'(d % m);
					term_phase = S_COEF;
				end else begin
					raise_error(ST_BAD_FIRST);
				end
			end
			S_COEF: begin
				if (digit_char(c)) coef_run = COEF_W'((64'(coef_run) * 10 + d) % m);
				else begin_item(c);
			end
			S_ITEM: begin_item(c);
			S_AFTER_VAR: begin
				if (c == CH_CARET) term_phase = S_CARET;
				else begin_item(c);
			end
			S_CARET: begin
				if (digit_char(c)) begin
					exp_run    = DEG_W'(d);
					term_phase = S_EXP;
				end else begin
					raise_error(ST_CARET);
				end
			end
			S_EXP: begin
				if (digit_char(c)) begin
					// saturate after every digit
					tmp     = 64'(exp_run) * 10 + d;
					exp_run = (tmp > 64'((1 << DEG_W) - 1)) ? '1 : DEG_W'(tmp);
				end else begin
					store_exponent();
					begin_item(c);
				end
			end
			default: ;
		endcase

		if (!eot) return;

		// a caret as the final character has no digit
		if (term_phase == S_CARET) raise_error(ST_CARET);
		else if (term_phase == S_EXP) store_exponent();

		if (term_phase == S_ERROR) begin
			pending_results.push_back('{'0, '0, '0, term_err, 1'b1});
		end else begin
			coef = 64'(coef_run) % m;
			n    = names_in_use();
			if (n == 0) begin
				pending_results.push_back('{'0, '0, COEF_W'(coef), ST_OK, 1'b1});
			end else begin
				for (int unsigned k = 0; k < n; k++)
					pending_results.push_back('{IDX_W'(k), deg_tab[k], COEF_W'(coef),
						ST_OK, k == n - 1});
			end
		end
		clear_term();
	endfunction

	// ---------------------------------------------------------------
	// stimulus helpers
	// ---------------------------------------------------------------

	// mostly back to back, often short gaps, now and then a long one
	function automatic int unsigned gap_len();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 55) return 0;
		if (roll < 93) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [CH_W-1:0] any_letter();
		if ($urandom_range(0, 1) != 0) return CH_W'(CH_UP_A + $urandom_range(0, 25));
		return CH_W'(CH_LO_A + $urandom_range(0, 25));
	endfunction

	// mostly a name from the active table, sometimes any letter
	function automatic logic [CH_W-1:0] pick_name();
		int unsigned n, slot;
		n = names_in_use();
		if (n != 0 && $urandom_range(0, 7) != 0) begin
			slot = $urandom_range(0, n - 1);
			return names_q[8*slot +: 8];
		end
		return any_letter();
	endfunction

	function automatic void push_digits(ref logic [CH_W-1:0] text[$], input int unsigned count);
		repeat (count) text.push_back(CH_W'(CH_ZERO + $urandom_range(0, 9)));
	endfunction

	// one character transfer; returns at the falling edge after acceptance
	task automatic send_char(input logic [CH_W-1:0] c, input logic eot);
		int unsigned gap;
		gap = idle_in ? gap_len() : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid    <= 1'b1;
		ch          <= c;
		end_of_term <= eot;
		do @(posedge clk); while (in_stall);
		parse_char(c, eot);
		@(negedge clk);
	endtask

	task automatic send_term(input logic [CH_W-1:0] text[$]);
		foreach (text[i]) send_char(text[i], i == text.size() - 1);
	endtask

	task automatic send_text(input string s);
		logic [CH_W-1:0] text[$];
		foreach (s[i]) text.push_back(s[i]);
		send_term(text);
	endtask

	// registers change only with the block idle: results drained, then a pause
	task automatic reconfigure(input logic [COEF_W-1:0] mod, input logic [CFG_W-1:0] names,
			input logic [NUMV_W-1:0] nv);
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_MODULUS;
		cfg_data  <= CFG_W'(mod);
		@(negedge clk);
		cfg_index <= CFG_VAR_NAMES;
		cfg_data  <= names;
		@(negedge clk);
		cfg_index <= CFG_NUM_VARS;
		cfg_data  <= CFG_W'(nv);
		@(negedge clk);
		cfg_we    <= 1'b0;
		modulus_q = mod;
		names_q   = names;
		nvars_q   = nv;
	endtask

	// random term: mostly well formed, some with one stray character inserted, a few pure noise
	task automatic make_term(output logic [CH_W-1:0] text[$]);
		int unsigned kind, pos;
		logic [CH_W-1:0] junk;
		text = {};
		kind = $urandom_range(0, 99);
		// optional coefficient, now and then long enough to wrap the modulus
		if ($urandom_range(0, 2) != 0)
			push_digits(text, ($urandom_range(0, 3) == 0) ? $urandom_range(8, 12)
				: $urandom_range(1, 3));
		repeat ($urandom_range(1, 4)) begin
			if (text.size() != 0 && $urandom_range(0, 2) == 0)
				repeat ($urandom_range(1, 2))
					text.push_back(($urandom_range(0, 1) != 0) ? CH_STAR : CH_SPACE);
			if (text.size() != 0 && $urandom_range(0, 7) == 0) begin
				text.push_back(CH_CARET);
				push_digits(text, $urandom_range(1, 2));
			end else begin
				text.push_back(pick_name());
				if ($urandom_range(0, 1) != 0) begin
					text.push_back(CH_CARET);
					push_digits(text, $urandom_range(1, 4));
				end
			end
		end
		if (kind >= 97) begin
			text = {};
			repeat ($urandom_range(1, 3)) text.push_back(CH_W'($urandom_range(0, 255)));
		end else if (kind >= 82) begin
			pos = $urandom_range(0, text.size());
			case ($urandom_range(0, 3))
				0:       junk = CH_W'($urandom_range(0, 255));
				1:       junk = CH_CARET;
				2:       junk = any_letter();
				default: junk = CH_W'(CH_ZERO + $urandom_range(0, 9));
			endcase
			text.insert(pos, junk);
		end
	endtask

	// ---------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------

	// reset settings: modulus 2^31-1, empty name table, one variable
	task automatic test_reset_values();
		send_text("42");
		send_text("x");
	endtask

	task automatic test_well_formed();
		reconfigure(MOD_MAX, NAMES_XYZ, NUMV_W'(3));
		send_text("12x^3y");
		// degree saturates
		send_text("x^999");
		// repeated variable keeps its last degree
		send_text("x^2x");
		// caret after a separator or a coefficient binds to nothing
		send_text("y*^5z");
		send_text("7^12");
	endtask

	task automatic test_error_cases();
		send_text("*");
		send_text("q");
		send_text("x^");
		// characters after the error are ignored
		send_text("x^*y");
		send_text("x7");
		send_text("x!");
	endtask

	task automatic test_register_extremes();
		// modulus one and no variables in use
		reconfigure(COEF_W'(1), NAMES_XYZ, NUMV_W'(0));
		send_text("5");
		// smallest real field, count above the table size
		reconfigure(COEF_W'(2), NAMES_XYZ, NUMV_W'(15));
		send_text("13y");
	endtask

	task automatic test_random_terms();
		logic [CH_W-1:0]   text[$];
		logic [CFG_W-1:0]  names;
		logic [COEF_W-1:0] mod;
		logic [NUMV_W-1:0] nv;
		int unsigned sent, phase_end;
		sent = 0;
		while (sent < RANDOM_CHARS) begin
			case ($urandom_range(0, 5))
				0:       mod = '0;
				1:       mod = COEF_W'(1);
				2:       mod = COEF_W'(2);
				3:       mod = MOD_MAX;
				4:       mod = COEF_W'($urandom_range(3, 1000));
				default: mod = COEF_W'($urandom());
			endcase
			if ($urandom_range(0, 5) == 0) begin
				names = {$urandom(), $urandom()};
			end else begin
				for (int i = 0; i < NAMES; i++) names[8*i +: 8] = any_letter();
			end
			nv = ($urandom_range(0, 9) == 0) ? NUMV_W'($urandom_range(0, 15))
				: NUMV_W'($urandom_range(1, NAMES));
			reconfigure(mod, names, nv);
			// some settings run with no idling on one side or both
			idle_in   = $urandom_range(0, 3) != 0;
			idle_out  = $urandom_range(0, 3) != 0;
			phase_end = sent + $urandom_range(40, 100);
			while (sent < phase_end && sent < RANDOM_CHARS) begin
				make_term(text);
				send_term(text);
				sent += text.size();
			end
		end
	endtask

	// ---------------------------------------------------------------
	// result side
	// ---------------------------------------------------------------

	// output stall with random gaps, changed on the falling edge
	initial begin
		int unsigned hold;
		out_stall = 1'b0;
		hold      = 0;
		forever begin
			@(negedge clk);
			if (hold != 0) begin
				out_stall <= 1'b1;
				hold--;
			end else begin
				out_stall <= 1'b0;
				if (idle_out) hold = gap_len();
			end
		end
	end

	// every result transfer is matched against the oldest expectation
	always @(posedge clk) begin
		term_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= SHOWN_ERRORS)
					$display("unexpected result: index %0d degree %0d coefficient %0d status %0d last %0d",
						var_index, degree, coefficient, status, last);
			end else begin
				want = pending_results.pop_front();
				if (var_index !== want.var_index || degree !== want.degree ||
						coefficient !== want.coefficient || status !== want.status ||
						last !== want.last) begin
					mismatches++;
					if (mismatches <= SHOWN_ERRORS)
						$display("result mismatch: expected %0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d %s",
							want.var_index, want.degree, want.coefficient, want.status,
							want.last, var_index, degree, coefficient, status, last,
							"(index/degree/coefficient/status/last)");
				end
			end
		end
	end

	// watchdog: too long without any transfer on either side
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
		else quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// sequence
	// ---------------------------------------------------------------

	initial begin
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = CFG_MODULUS;
		cfg_data    = '0;
		in_valid    = 1'b0;
		ch          = '0;
		end_of_term = 1'b0;
		modulus_q   = MODULUS_RST;
		names_q     = '0;
		nvars_q     = NUM_VARS_RST;
		clear_term();
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_values();
		test_well_formed();
		test_error_cases();
		test_register_extremes();
		test_random_terms();

		// drain, then allow for anything late
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

### sim.f
+incdir+rtl
rtl/mtp_pkg.sv
rtl/mtp_datapath.sv
rtl/mtp_ctrl.sv
rtl/monomial_term_parser_core.sv
dv/tb.sv
